FILE: src/sc1kd_pkg.sv
// sc1kd_pkg: shared types, scan code constants and lookup tables for the
// scan code set 1 key decoder. No dependencies.
`timescale 1ns / 1ps

package sc1kd_pkg;

    localparam int ROW_W   = 3;
    localparam int COL_W   = 5;
    localparam int ASCII_W = 7;

    // physical position of a key
    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
    } key_pos_t;

    localparam logic [7:0] PREFIX_BYTE     = 8'hE0;
    localparam logic [7:0] CTRL_MAKE       = 8'h1D;
    localparam logic [7:0] CTRL_BREAK      = 8'h9D;
    localparam logic [7:0] ALT_MAKE        = 8'h38;
    localparam logic [7:0] ALT_BREAK       = 8'hB8;
    localparam logic [7:0] LSHIFT_MAKE     = 8'h2A;
    localparam logic [7:0] RSHIFT_MAKE     = 8'h36;
    localparam logic [7:0] LSHIFT_BREAK    = 8'hAA;
    localparam logic [7:0] RSHIFT_BREAK    = 8'hB6;
    localparam logic [7:0] LSUPER_MAKE     = 8'h5B;
    localparam logic [7:0] RSUPER_MAKE     = 8'h5C;
    localparam logic [7:0] LSUPER_BREAK    = 8'hDB;
    localparam logic [7:0] RSUPER_BREAK    = 8'hDC;
    localparam logic [7:0] CAPS_MAKE       = 8'h3A;
    localparam logic [7:0] CAPS_BREAK      = 8'hBA;
    localparam logic [ASCII_W-1:0] CHAR_C  = 7'h63;

    localparam logic        LAYOUT_QWERTY = 1'b0;
    localparam logic        LAYOUT_DVORAK = 1'b1;
    localparam logic        LAYOUT_RESET  = LAYOUT_QWERTY;

    typedef logic [0:5][0:15][7:0] char_tab_t;

    localparam logic [0:15][7:0] ROW0 = {8'h00, 8'h1B, 112'h0};
    localparam logic [0:15][7:0] ROW5 = {" ", 120'h0};

    localparam char_tab_t QWERTY_PLAIN = {
        ROW0,
        {"`1234567890-=", 8'h08, 16'h0},
        {8'h09, "qwertyuiop[]\\", 8'h7F, 8'h00},
        {"asdfghjkl;'", 8'h0A, 32'h0},
        {"zxcvbnm,./", 48'h0},
        ROW5
    };
    localparam char_tab_t QWERTY_SHIFT = {
        ROW0,
        {"~!@#$%^&*()_+", 8'h08, 16'h0},
        {8'h09, "QWERTYUIOP{}|", 8'h7F, 8'h00},
        {"ASDFGHJKL:\"", 8'h0A, 32'h0},
        {"ZXCVBNM<>?", 48'h0},
        ROW5
    };
    localparam char_tab_t DVORAK_PLAIN = {
        ROW0,
        {"`1234567890[]", 8'h08, 16'h0},
        {8'h09, "',.pyfgcrl/=\\", 8'h7F, 8'h00},
        {"aoeuidhtns-", 8'h0A, 32'h0},
        {";qjkxbmwvz", 48'h0},
        ROW5
    };
    localparam char_tab_t DVORAK_SHIFT = {
        ROW0,
        {"~!@#$%^&*(){}", 8'h08, 16'h0},
        {8'h09, "\"<>PYFGCRL?+|", 8'h7F, 8'h00},
        {"AOEUIDHTNS_", 8'h0A, 32'h0},
        {":QJKXBMWVZ", 48'h0},
        ROW5
    };

    // code (prefix flag, byte) to physical position, zero for unmapped codes
    function automatic key_pos_t locate(input logic pfx, input logic [7:0] b);
        key_pos_t p;
        p = '0;
        case ({pfx, b})
            9'h001: p = '{3'd0, 5'd1};   9'h03B: p = '{3'd0, 5'd2};
            9'h03C: p = '{3'd0, 5'd3};   9'h03D: p = '{3'd0, 5'd4};
            9'h03E: p = '{3'd0, 5'd5};   9'h03F: p = '{3'd0, 5'd6};
            9'h040: p = '{3'd0, 5'd7};   9'h041: p = '{3'd0, 5'd8};
            9'h042: p = '{3'd0, 5'd9};   9'h043: p = '{3'd0, 5'd10};
            9'h044: p = '{3'd0, 5'd11};  9'h057: p = '{3'd0, 5'd12};
            9'h058: p = '{3'd0, 5'd13};
            9'h029: p = '{3'd1, 5'd0};   9'h002: p = '{3'd1, 5'd1};
            9'h003: p = '{3'd1, 5'd2};   9'h004: p = '{3'd1, 5'd3};
            9'h005: p = '{3'd1, 5'd4};   9'h006: p = '{3'd1, 5'd5};
            9'h007: p = '{3'd1, 5'd6};   9'h008: p = '{3'd1, 5'd7};
            9'h009: p = '{3'd1, 5'd8};   9'h00A: p = '{3'd1, 5'd9};
            9'h00B: p = '{3'd1, 5'd10};  9'h00C: p = '{3'd1, 5'd11};
            9'h00D: p = '{3'd1, 5'd12};  9'h00E: p = '{3'd1, 5'd13};
            9'h152: p = '{3'd1, 5'd14};  9'h147: p = '{3'd1, 5'd15};
            9'h149: p = '{3'd1, 5'd16};
            9'h00F: p = '{3'd2, 5'd0};   9'h010: p = '{3'd2, 5'd1};
            9'h011: p = '{3'd2, 5'd2};   9'h012: p = '{3'd2, 5'd3};
            9'h013: p = '{3'd2, 5'd4};   9'h014: p = '{3'd2, 5'd5};
            9'h015: p = '{3'd2, 5'd6};   9'h016: p = '{3'd2, 5'd7};
            9'h017: p = '{3'd2, 5'd8};   9'h018: p = '{3'd2, 5'd9};
            9'h019: p = '{3'd2, 5'd10};  9'h01A: p = '{3'd2, 5'd11};
            9'h01B: p = '{3'd2, 5'd12};  9'h02B: p = '{3'd2, 5'd13};
            9'h153: p = '{3'd2, 5'd14};  9'h14F: p = '{3'd2, 5'd15};
            9'h151: p = '{3'd2, 5'd16};
            9'h01E: p = '{3'd3, 5'd0};   9'h01F: p = '{3'd3, 5'd1};
            9'h020: p = '{3'd3, 5'd2};   9'h021: p = '{3'd3, 5'd3};
            9'h022: p = '{3'd3, 5'd4};   9'h023: p = '{3'd3, 5'd5};
            9'h024: p = '{3'd3, 5'd6};   9'h025: p = '{3'd3, 5'd7};
            9'h026: p = '{3'd3, 5'd8};   9'h027: p = '{3'd3, 5'd9};
            9'h028: p = '{3'd3, 5'd10};  9'h01C: p = '{3'd3, 5'd11};
            9'h02C: p = '{3'd4, 5'd0};   9'h02D: p = '{3'd4, 5'd1};
            9'h02E: p = '{3'd4, 5'd2};   9'h02F: p = '{3'd4, 5'd3};
            9'h030: p = '{3'd4, 5'd4};   9'h031: p = '{3'd4, 5'd5};
            9'h032: p = '{3'd4, 5'd6};   9'h033: p = '{3'd4, 5'd7};
            9'h034: p = '{3'd4, 5'd8};   9'h035: p = '{3'd4, 5'd9};
            9'h148: p = '{3'd4, 5'd10};
            9'h039: p = '{3'd5, 5'd0};   9'h14B: p = '{3'd5, 5'd1};
            9'h150: p = '{3'd5, 5'd2};   9'h14D: p = '{3'd5, 5'd3};
            default: p = '0;
        endcase
        return p;
    endfunction

    // ascii for a position; caps lock swaps letter case
    function automatic logic [ASCII_W-1:0] translate(input logic lay, input logic shift,
                                                     input logic caps, input key_pos_t p);
        logic [7:0] ch;
        ch = 8'h00;
        if (p.col[COL_W-1] == 1'b0 && p.row <= 3'd5) begin
            case ({lay, shift})
                2'b00:   ch = QWERTY_PLAIN[p.row][p.col[3:0]];
                2'b01:   ch = QWERTY_SHIFT[p.row][p.col[3:0]];
                2'b10:   ch = DVORAK_PLAIN[p.row][p.col[3:0]];
                default: ch = DVORAK_SHIFT[p.row][p.col[3:0]];
            endcase
        end
        if (caps) begin
            if (ch >= 8'h41 && ch <= 8'h5A) begin
                ch = ch + 8'd32;
            end else if (ch >= 8'h61 && ch <= 8'h7A) begin
                ch = ch - 8'd32;
            end
        end
        return ch[ASCII_W-1:0];
    endfunction

endpackage

FILE: src/scancode_set1_key_decoder.sv
// scancode_set1_key_decoder: scan code set 1 byte stream to key position,
// ascii and modifier flags. Depends on sc1kd_pkg.
`timescale 1ns / 1ps

// channel   direction  handshake            payload
// cfg       in         cfg_valid/cfg_ready  cfg_layout
// s         in         s_valid/s_ready      s_scan_byte
// m         out        m_valid/m_ready      m_row .. m_interrupt_request
//
// one byte per cycle unless s_ready is low: decode, position lookup and
// ascii table read sit between the input port and the result register
// a 0xE0 prefix byte is absorbed and gives no result request
// s_ready drops only while a result is held and m_ready is low
// synchronous active-low reset clears flags, prefix, layout and m_valid
// cfg_ready is always high

module scancode_set1_key_decoder (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic                          cfg_layout,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [7:0]                    s_scan_byte,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [sc1kd_pkg::ROW_W-1:0]   m_row,
    output logic [sc1kd_pkg::COL_W-1:0]   m_col,
    output logic [sc1kd_pkg::ASCII_W-1:0] m_ascii,
    output logic                          m_key_pressed,
    output logic                          m_ctrl_down,
    output logic                          m_alt_down,
    output logic                          m_shift_down,
    output logic                          m_super_down,
    output logic                          m_caps_active,
    output logic                          m_interrupt_request
);

    // held state
    logic layout_reg;
    logic prefix_reg, prefix_next;
    logic ctrl_reg, ctrl_next;
    logic alt_reg, alt_next;
    logic shift_reg, shift_next;
    logic super_reg, super_next;
    logic caps_on_reg, caps_on_next;
    logic caps_down_reg, caps_down_next;

    // result register
    logic                          m_valid_reg, m_valid_next;
    logic [sc1kd_pkg::ROW_W-1:0]   row_reg;
    logic [sc1kd_pkg::COL_W-1:0]   col_reg;
    logic [sc1kd_pkg::ASCII_W-1:0] ascii_reg;
    logic                          pressed_reg;
    logic                          ctrl_out_reg, alt_out_reg, shift_out_reg;
    logic                          super_out_reg, caps_out_reg, irq_reg;

    logic                          accept;
    logic                          is_prefix;
    logic                          modifier;
    sc1kd_pkg::key_pos_t           pos;
    logic [sc1kd_pkg::ASCII_W-1:0] ch;

    assign cfg_ready = 1'b1;
    assign s_ready   = !m_valid_reg || m_ready;
    assign accept    = s_valid && s_ready;
    assign is_prefix = (s_scan_byte == sc1kd_pkg::PREFIX_BYTE);

    // modifier decode and flag update
    always_comb begin
        prefix_next    = prefix_reg;
        ctrl_next      = ctrl_reg;
        alt_next       = alt_reg;
        shift_next     = shift_reg;
        super_next     = super_reg;
        caps_on_next   = caps_on_reg;
        caps_down_next = caps_down_reg;
        modifier       = 1'b1;
        // ctrl and alt are the same with or without prefix
        if (s_scan_byte == sc1kd_pkg::CTRL_MAKE) begin
            ctrl_next = 1'b1;
        end else if (s_scan_byte == sc1kd_pkg::CTRL_BREAK) begin
            ctrl_next = 1'b0;
        end else if (s_scan_byte == sc1kd_pkg::ALT_MAKE) begin
            alt_next = 1'b1;
        end else if (s_scan_byte == sc1kd_pkg::ALT_BREAK) begin
            alt_next = 1'b0;
        end else if (!prefix_reg && (s_scan_byte == sc1kd_pkg::LSHIFT_MAKE ||
                                     s_scan_byte == sc1kd_pkg::RSHIFT_MAKE)) begin
            shift_next = 1'b1;
        end else if (!prefix_reg && (s_scan_byte == sc1kd_pkg::LSHIFT_BREAK ||
                                     s_scan_byte == sc1kd_pkg::RSHIFT_BREAK)) begin
            shift_next = 1'b0;
        end else if (prefix_reg && (s_scan_byte == sc1kd_pkg::LSUPER_MAKE ||
                                    s_scan_byte == sc1kd_pkg::RSUPER_MAKE)) begin
            super_next = 1'b1;
        end else if (prefix_reg && (s_scan_byte == sc1kd_pkg::LSUPER_BREAK ||
                                    s_scan_byte == sc1kd_pkg::RSUPER_BREAK)) begin
            super_next = 1'b0;
        end else if (!prefix_reg && s_scan_byte == sc1kd_pkg::CAPS_MAKE) begin
            // toggle once per press, auto-repeat ignored
            if (!caps_down_reg) begin
                caps_on_next = !caps_on_reg;
            end
            caps_down_next = 1'b1;
        end else if (!prefix_reg && s_scan_byte == sc1kd_pkg::CAPS_BREAK) begin
            caps_down_next = 1'b0;
        end else begin
            modifier = 1'b0;
        end
        // prefix byte only arms; any other byte consumes the prefix
        if (is_prefix) begin
            prefix_next    = 1'b1;
            ctrl_next      = ctrl_reg;
            alt_next       = alt_reg;
            shift_next     = shift_reg;
            super_next     = super_reg;
            caps_on_next   = caps_on_reg;
            caps_down_next = caps_down_reg;
        end else begin
            prefix_next = 1'b0;
        end
    end

    // position and character lookup
    always_comb begin
        pos = modifier ? '0 : sc1kd_pkg::locate(prefix_reg, s_scan_byte);
        ch  = sc1kd_pkg::translate(layout_reg, shift_next, caps_on_next, pos);
    end

    always_comb begin
        if (accept && !is_prefix) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            layout_reg    <= sc1kd_pkg::LAYOUT_RESET;
            prefix_reg    <= 1'b0;
            ctrl_reg      <= 1'b0;
            alt_reg       <= 1'b0;
            shift_reg     <= 1'b0;
            super_reg     <= 1'b0;
            caps_on_reg   <= 1'b0;
            caps_down_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (cfg_valid) begin
                layout_reg <= cfg_layout;
            end
            if (accept) begin
                prefix_reg    <= prefix_next;
                ctrl_reg      <= ctrl_next;
                alt_reg       <= alt_next;
                shift_reg     <= shift_next;
                super_reg     <= super_next;
                caps_on_reg   <= caps_on_next;
                caps_down_reg <= caps_down_next;
            end
        end
    end

    // result payload, loaded with each non-prefix request
    always_ff @(posedge aclk) begin
        if (accept && !is_prefix) begin
            row_reg       <= pos.row;
            col_reg       <= pos.col;
            ascii_reg     <= ch;
            pressed_reg   <= (pos != '0);
            ctrl_out_reg  <= ctrl_next;
            alt_out_reg   <= alt_next;
            shift_out_reg <= shift_next;
            super_out_reg <= super_next;
            caps_out_reg  <= caps_on_next;
            irq_reg       <= (ch == sc1kd_pkg::CHAR_C) && ctrl_next;
        end
    end

    assign m_valid             = m_valid_reg;
    assign m_row               = row_reg;
    assign m_col               = col_reg;
    assign m_ascii             = ascii_reg;
    assign m_key_pressed       = pressed_reg;
    assign m_ctrl_down         = ctrl_out_reg;
    assign m_alt_down          = alt_out_reg;
    assign m_shift_down        = shift_out_reg;
    assign m_super_down        = super_out_reg;
    assign m_caps_active       = caps_out_reg;
    assign m_interrupt_request = irq_reg;

endmodule
